>>> design/ntg_pkg.sv
// Shared types, constants and note tables for the note tone generator.
// No dependencies; imported by every module of the block.
package ntg_pkg;

	localparam int NOTE_COUNT = 14;
	localparam int IDX_W      = 4;
	localparam int BEAT_W     = 8;
	localparam int HALF_W     = 11;
	localparam int WAVES_W    = 7;
	localparam int PER_W      = 15;
	localparam int PAUSE_W    = 16;
	localparam logic [PAUSE_W-1:0] PAUSE_RESET = 16'd50000;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Classified word handed from the front to the back.
	typedef struct packed {
		logic              is_cmd;
		logic              tone;
		logic [HALF_W-1:0] half_period;
		logic [PER_W-1:0]  periods;
	} ntg_item_t;

	// Back-end status seen by the top level.
	typedef struct packed {
		logic in_tone;
		logic level;
		logic half_zero;
	} ntg_status_t;

	// Half period in microseconds, C4..B5.
	function automatic logic [HALF_W-1:0] half_us(input logic [IDX_W-1:0] idx);
		logic [HALF_W-1:0] v;
		case (idx)
			4'd0:    v = 11'd1911;
			4'd1:    v = 11'd1703;
			4'd2:    v = 11'd1517;
			4'd3:    v = 11'd1432;
			4'd4:    v = 11'd1276;
			4'd5:    v = 11'd1136;
			4'd6:    v = 11'd1012;
			4'd7:    v = 11'd956;
			4'd8:    v = 11'd851;
			4'd9:    v = 11'd758;
			4'd10:   v = 11'd716;
			4'd11:   v = 11'd638;
			4'd12:   v = 11'd568;
			4'd13:   v = 11'd506;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Full periods in one 100 ms beat, C4..B5.
	function automatic logic [WAVES_W-1:0] waves(input logic [IDX_W-1:0] idx);
		logic [WAVES_W-1:0] v;
		case (idx)
			4'd0:    v = 7'd26;
			4'd1:    v = 7'd29;
			4'd2:    v = 7'd33;
			4'd3:    v = 7'd35;
			4'd4:    v = 7'd39;
			4'd5:    v = 7'd44;
			4'd6:    v = 7'd49;
			4'd7:    v = 7'd52;
			4'd8:    v = 7'd59;
			4'd9:    v = 7'd66;
			4'd10:   v = 7'd70;
			4'd11:   v = 7'd78;
			4'd12:   v = 7'd88;
			4'd13:   v = 7'd99;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> design/ntg_front.sv
// Front end: accepts input words, looks up the note tables and works out
// the period count. Depends on ntg_pkg.
module ntg_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_mode,
	input  logic [ntg_pkg::IDX_W-1:0]  in_idx,
	input  logic [ntg_pkg::BEAT_W-1:0] in_beats,
	output logic                     push,
	output ntg_pkg::ntg_item_t       push_item,
	input  logic                     q_full
);
	import ntg_pkg::*;

	logic              valid_s1;
	ntg_item_t         item_s1;
	ntg_item_t         item_d;
	logic [PER_W-1:0]  periods_d;
	logic [HALF_W-1:0] half_d;
	logic              idx_ok;
	logic              advance;

	assign idx_ok    = (in_idx < IDX_W'(NOTE_COUNT));
	assign half_d    = half_us(in_idx);
	assign periods_d = PER_W'(waves(in_idx)) * PER_W'(in_beats);

	always_comb begin
		item_d.is_cmd      = in_mode;
		item_d.tone        = in_mode && idx_ok && (periods_d != '0) && (half_d != '0);
		item_d.half_period = half_d;
		item_d.periods     = periods_d;
	end

	assign push     = valid_s1 && !q_full;
	assign advance  = !valid_s1 || !q_full;
	assign in_ready = advance;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> design/ntg_queue.sv
// Short word queue between front and back end.
// Depends on ntg_pkg for the word type and depth.
module ntg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ntg_pkg::ntg_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output ntg_pkg::ntg_item_t head_item
);
	import ntg_pkg::*;

	ntg_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> design/ntg_back.sv
// Back end: tone and pause sequencer, pause register and output word register.
// Depends on ntg_pkg.
module ntg_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  ntg_pkg::ntg_item_t           head_item,
	output logic                         pop,
	input  logic                         cfg_we,
	input  logic [ntg_pkg::PAUSE_W-1:0]  cfg_wdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ntg_pkg::OUT_DATA_W-1:0] out_data,
	output ntg_pkg::ntg_status_t         status
);
	import ntg_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TONE  = 2'd1;
	localparam logic [1:0] PH_PAUSE = 2'd2;

	logic [1:0]         phase_q,  phase_d;
	logic               level_q,  level_d;
	logic [HALF_W-1:0]  half_period_q, half_period_d;
	logic [HALF_W-1:0]  half_count_q,  half_count_d;
	logic [PER_W-1:0]   periods_left_q, periods_left_d;
	logic [PER_W-1:0]   periods_dec;
	logic [PAUSE_W-1:0] pause_count_q, pause_count_d;
	logic [PAUSE_W-1:0] pause_ticks_q;
	logic               taken_d;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign pop         = head_valid && (!out_valid_q || out_ready);
	assign periods_dec = periods_left_q - PER_W'(1);

	always_comb begin
		phase_d        = phase_q;
		level_d        = level_q;
		half_period_d  = half_period_q;
		half_count_d   = half_count_q;
		periods_left_d = periods_left_q;
		pause_count_d  = pause_count_q;
		taken_d        = 1'b0;
		if (head_item.is_cmd) begin
			if (phase_q == PH_IDLE) begin
				taken_d       = 1'b1;
				half_period_d = head_item.half_period;
				if (head_item.tone) begin
					phase_d        = PH_TONE;
					level_d        = 1'b1;
					half_count_d   = head_item.half_period;
					periods_left_d = head_item.periods;
				end else begin
					level_d        = 1'b0;
					half_count_d   = '0;
					periods_left_d = '0;
					phase_d        = (pause_ticks_q == '0) ? PH_IDLE : PH_PAUSE;
					pause_count_d  = pause_ticks_q;
				end
			end
		end else begin
			unique case (phase_q)
				PH_TONE: begin
					if (half_count_q > HALF_W'(1)) begin
						half_count_d = half_count_q - HALF_W'(1);
					end else if (level_q) begin
						level_d      = 1'b0;
						half_count_d = half_period_q;
					end else if (periods_dec == '0) begin
						// last period done: start the pause, or go idle if the pause is zero
						level_d        = 1'b0;
						half_count_d   = '0;
						periods_left_d = '0;
						phase_d        = (pause_ticks_q == '0) ? PH_IDLE : PH_PAUSE;
						pause_count_d  = pause_ticks_q;
					end else begin
						periods_left_d = periods_dec;
						level_d        = 1'b1;
						half_count_d   = half_period_q;
					end
				end
				PH_PAUSE: begin
					if (pause_count_q > PAUSE_W'(1)) begin
						pause_count_d = pause_count_q - PAUSE_W'(1);
					end else begin
						pause_count_d = '0;
						phase_d       = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			level_q        <= 1'b0;
			half_period_q  <= '0;
			half_count_q   <= '0;
			periods_left_q <= '0;
			pause_count_q  <= '0;
			pause_ticks_q  <= PAUSE_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				pause_ticks_q <= cfg_wdata;
			end
			if (pop) begin
				phase_q        <= phase_d;
				level_q        <= level_d;
				half_period_q  <= half_period_d;
				half_count_q   <= half_count_d;
				periods_left_q <= periods_left_d;
				pause_count_q  <= pause_count_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {{(OUT_DATA_W-3){1'b0}}, taken_d, (phase_d != PH_IDLE), level_d};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign status.in_tone   = (phase_q == PH_TONE);
	assign status.level     = level_q;
	assign status.half_zero = (half_count_q == '0);

endmodule

>>> design/note_tone_generator.sv
// Note tone generator top level: front end, word queue and tone sequencer.
// Path: front-end register, word queue, back-end output register; stalls can hold a word.
// Throughput: one word per cycle unless the output stalls; the sequencer updates on each pop.
// Reset (arst_n, async, low): sequencer idle, level low, queue empty, pause 50000.
// Depends on ntg_pkg, ntg_front, ntg_queue and ntg_back.
module note_tone_generator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [ntg_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [3:0] note_index, [11:4] beat_count
	input  logic                   s_axis_tuser,  // [0] mode
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [ntg_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [0] buzzer_level, [1] busy_res, [2] accepted
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ntg_pkg::PAUSE_W-1:0]    cfg_data
);
	import ntg_pkg::*;

	logic        push;
	ntg_item_t   push_item;
	logic        q_full;
	logic        pop;
	logic        head_valid;
	ntg_item_t   head_item;
	ntg_status_t status;

	assign cfg_ready = 1'b1;

	ntg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_idx    (s_axis_tdata[IDX_W-1:0]),
		.in_beats  (s_axis_tdata[IDX_W+BEAT_W-1:IDX_W]),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	ntg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	ntg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.status     (status)
	);

`ifndef SYNTHESIS
	a_level_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
		else $error("buzzer high while block reports idle");

	a_level_tone: assert property (@(posedge clk) disable iff (!arst_n)
		status.level |-> status.in_tone)
		else $error("level high outside tone phase");

	a_half_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		status.in_tone |-> !status.half_zero)
		else $error("half period counter empty during tone");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_full)
		else $error("input stalled while queue has room");
`endif

endmodule
